// ===== design/agl_pkg.sv =====
`default_nettype none

package agl_pkg;

    localparam int QUBITS    = 64;
    localparam int LAYERS    = 1024;
    localparam int QIDX_W    = $clog2(QUBITS);
    localparam int LAYER_W   = $clog2(LAYERS);
    localparam int LVAL_W    = LAYER_W + 1;
    localparam int CNT_W     = 7;
    localparam int QIU_W     = QIDX_W + 1;

    localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'((1 << CNT_W) - 1);
    localparam logic [LAYER_W-1:0] LAYER_LAST = LAYER_W'(LAYERS - 1);
    localparam logic [LVAL_W-1:0]  LAYER_LIM  = LVAL_W'(LAYERS);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_QUBITS_IN_USE = REG_IDX_W'(0);
    localparam logic [QIU_W-1:0]     QIU_RESET         = QIU_W'(QUBITS);

    typedef struct packed {
        logic               valid;
        logic [LAYER_W-1:0] layer;
        logic               overflow;
        logic               bad;
    } stage_word_t;

endpackage

`default_nettype wire

// ===== design/agl_gate_if.sv =====
`default_nettype none

interface agl_gate_if;
    logic                       valid;
    logic                       ready;
    logic [agl_pkg::QIDX_W-1:0] target_qubit;
    logic                       has_control;
    logic [agl_pkg::QIDX_W-1:0] control_qubit;

    modport source (
        output valid, target_qubit, has_control, control_qubit,
        input  ready
    );

    modport sink (
        input  valid, target_qubit, has_control, control_qubit,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/agl_result_if.sv =====
`default_nettype none

interface agl_result_if;
    logic                        valid;
    logic                        ready;
    logic [agl_pkg::LAYER_W-1:0] assigned_layer;
    logic [agl_pkg::CNT_W-1:0]   layer_fill;
    logic [agl_pkg::CNT_W-1:0]   widest_layer;
    logic                        layer_overflow;
    logic                        bad_qubit;

    modport source (
        output valid, assigned_layer, layer_fill, widest_layer, layer_overflow, bad_qubit,
        input  ready
    );

    modport sink (
        input  valid, assigned_layer, layer_fill, widest_layer, layer_overflow, bad_qubit,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/agl_apb_regs.sv =====
`default_nettype none

module agl_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [agl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [agl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [agl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [agl_pkg::QIU_W-1:0]        qubits_in_use
);
    import agl_pkg::*;

    logic [QIU_W-1:0]     qiu_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx       = paddr[APB_ADDR_W-1:2];
    assign wr_en         = psel && penable && pwrite;
    assign pready        = 1'b1;
    assign qubits_in_use = qiu_reg;

    always_comb
    begin
        unique case (reg_idx)
            REG_QUBITS_IN_USE: prdata = APB_DATA_W'(qiu_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qiu_reg <= QIU_RESET;
        end
        else if (wr_en && reg_idx == REG_QUBITS_IN_USE)
        begin
            qiu_reg <= pwdata[QIU_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/agl_qubit_stage.sv =====
`default_nettype none

module agl_qubit_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    agl_gate_if.sink                    gate_in,
    input  logic [agl_pkg::QIU_W-1:0]   qubits_in_use,
    output agl_pkg::stage_word_t        s1_word,
    input  logic                        s2_ready
);
    import agl_pkg::*;

    // two banks, one write port each: bank a takes target, bank b takes control
    logic [LVAL_W-1:0] mem_a [QUBITS];
    logic [LVAL_W-1:0] mem_b [QUBITS];
    logic [QUBITS-1:0] written_reg;
    logic [QUBITS-1:0] sel_b_reg;

    logic              s1_valid_reg;
    logic [QIDX_W-1:0] t_reg;
    logic [QIDX_W-1:0] c_reg;
    logic              two_reg;
    logic [LVAL_W-1:0] rda_t_reg;
    logic [LVAL_W-1:0] rdb_t_reg;
    logic [LVAL_W-1:0] rda_c_reg;
    logic [LVAL_W-1:0] rdb_c_reg;
    logic              wr_t_reg;
    logic              wr_c_reg;
    logic              sel_t_reg;
    logic              sel_c_reg;

    // newest committed update, bypasses the bank write of the same edge
    logic              lw_valid_reg;
    logic [QIDX_W-1:0] lw_t_reg;
    logic [QIDX_W-1:0] lw_c_reg;
    logic              lw_two_reg;
    logic [LVAL_W-1:0] lw_val_reg;

    logic              accept;
    logic              commit;
    logic              bad;
    logic              hit_t;
    logic              hit_c;
    logic [LVAL_W-1:0] mem_t;
    logic [LVAL_W-1:0] mem_c;
    logic [LVAL_W-1:0] last_t;
    logic [LVAL_W-1:0] last_c;
    logic [LVAL_W-1:0] raw_layer;
    logic              ovf;
    logic [LAYER_W-1:0] layer;
    logic [LVAL_W-1:0] new_val;

    assign gate_in.ready = !s1_valid_reg || s2_ready;
    assign accept        = gate_in.valid && gate_in.ready;

    always_comb
    begin
        bad = !({1'b0, t_reg} < qubits_in_use)
            || (two_reg && !({1'b0, c_reg} < qubits_in_use));

        mem_t = !wr_t_reg ? '0 : (sel_t_reg ? rdb_t_reg : rda_t_reg);
        mem_c = !wr_c_reg ? '0 : (sel_c_reg ? rdb_c_reg : rda_c_reg);
        hit_t = lw_valid_reg && (t_reg == lw_t_reg || (lw_two_reg && t_reg == lw_c_reg));
        hit_c = lw_valid_reg && (c_reg == lw_t_reg || (lw_two_reg && c_reg == lw_c_reg));
        last_t = hit_t ? lw_val_reg : mem_t;
        last_c = hit_c ? lw_val_reg : mem_c;

        raw_layer = (two_reg && last_c > last_t) ? last_c : last_t;
        ovf       = raw_layer >= LAYER_LIM;
        layer     = ovf ? LAYER_LAST : raw_layer[LAYER_W-1:0];
        new_val   = {1'b0, layer} + LVAL_W'(1);

        s1_word.valid    = s1_valid_reg;
        s1_word.layer    = bad ? '0 : layer;
        s1_word.overflow = !bad && ovf;
        s1_word.bad      = bad;
    end

    assign commit = s1_valid_reg && s2_ready && !bad;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg     <= gate_in.target_qubit;
            c_reg     <= gate_in.control_qubit;
            two_reg   <= gate_in.has_control;
            rda_t_reg <= mem_a[gate_in.target_qubit];
            rdb_t_reg <= mem_b[gate_in.target_qubit];
            rda_c_reg <= mem_a[gate_in.control_qubit];
            rdb_c_reg <= mem_b[gate_in.control_qubit];
            wr_t_reg  <= written_reg[gate_in.target_qubit];
            wr_c_reg  <= written_reg[gate_in.control_qubit];
            sel_t_reg <= sel_b_reg[gate_in.target_qubit];
            sel_c_reg <= sel_b_reg[gate_in.control_qubit];
        end
        if (commit)
        begin
            mem_a[t_reg] <= new_val;
            if (two_reg)
            begin
                mem_b[c_reg] <= new_val;
            end
            lw_t_reg   <= t_reg;
            lw_c_reg   <= c_reg;
            lw_two_reg <= two_reg;
            lw_val_reg <= new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            written_reg  <= '0;
            sel_b_reg    <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                lw_valid_reg        <= 1'b1;
                written_reg[t_reg]  <= 1'b1;
                sel_b_reg[t_reg]    <= 1'b0;
                if (two_reg)
                begin
                    written_reg[c_reg] <= 1'b1;
                    sel_b_reg[c_reg]   <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/agl_count_stage.sv =====
`default_nettype none

module agl_count_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  agl_pkg::stage_word_t s1_word,
    output logic                 s2_ready,
    agl_result_if.source         result_out
);
    import agl_pkg::*;

    logic [CNT_W-1:0]   cnt_mem [LAYERS];

    logic               s2_valid_reg;
    logic [LAYER_W-1:0] s2_layer_reg;
    logic               s2_ovf_reg;
    logic               s2_bad_reg;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               rd_ok_reg;

    // layers at or above the high-water mark were never written since reset
    logic [LVAL_W-1:0]  hw_reg;
    logic [LVAL_W-1:0]  hw_next;
    logic [CNT_W-1:0]   max_reg;
    logic [CNT_W-1:0]   max_next;

    logic               lc_valid_reg;
    logic [LAYER_W-1:0] lc_layer_reg;
    logic [CNT_W-1:0]   lc_cnt_reg;

    logic               out_valid_reg;
    logic [LAYER_W-1:0] out_layer_reg;
    logic [CNT_W-1:0]   out_fill_reg;
    logic [CNT_W-1:0]   out_widest_reg;
    logic               out_ovf_reg;
    logic               out_bad_reg;

    logic               out_free;
    logic               s2_leave;
    logic               load;
    logic               commit;
    logic [CNT_W-1:0]   base;
    logic [CNT_W-1:0]   cnt;
    logic [LVAL_W-1:0]  layer_p1;

    assign out_free = !out_valid_reg || result_out.ready;
    assign s2_leave = s2_valid_reg && out_free;
    assign s2_ready = !s2_valid_reg || out_free;
    assign load     = s1_word.valid && s2_ready;
    assign commit   = s2_leave && !s2_bad_reg;

    always_comb
    begin
        if (lc_valid_reg && lc_layer_reg == s2_layer_reg)
        begin
            base = lc_cnt_reg;
        end
        else
        begin
            base = rd_ok_reg ? rd_cnt_reg : '0;
        end
        cnt      = (base == CNT_MAX) ? base : base + CNT_W'(1);
        max_next = (!s2_bad_reg && cnt > max_reg) ? cnt : max_reg;
        layer_p1 = {1'b0, s2_layer_reg} + LVAL_W'(1);
        hw_next  = (commit && layer_p1 > hw_reg) ? layer_p1 : hw_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_layer_reg <= s1_word.layer;
            s2_ovf_reg   <= s1_word.overflow;
            s2_bad_reg   <= s1_word.bad;
            rd_cnt_reg   <= cnt_mem[s1_word.layer];
            rd_ok_reg    <= {1'b0, s1_word.layer} < hw_reg;
        end
        if (commit)
        begin
            cnt_mem[s2_layer_reg] <= cnt;
            lc_layer_reg          <= s2_layer_reg;
            lc_cnt_reg            <= cnt;
        end
        if (s2_leave)
        begin
            out_layer_reg  <= s2_layer_reg;
            out_fill_reg   <= s2_bad_reg ? '0 : cnt;
            out_widest_reg <= max_next;
            out_ovf_reg    <= s2_ovf_reg;
            out_bad_reg    <= s2_bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lc_valid_reg  <= 1'b0;
            hw_reg        <= '0;
            max_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_leave)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                lc_valid_reg <= 1'b1;
            end
            hw_reg  <= hw_next;
            max_reg <= s2_leave ? max_next : max_reg;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.assigned_layer = out_layer_reg;
    assign result_out.layer_fill     = out_fill_reg;
    assign result_out.widest_layer   = out_widest_reg;
    assign result_out.layer_overflow = out_ovf_reg;
    assign result_out.bad_qubit      = out_bad_reg;

endmodule

`default_nettype wire

// ===== design/asap_gate_layering.sv =====
// A gate word accepted on gate_in passes the qubit lookup stage and the layer counter
//   stage, and its result word is registered in the output register.
// Throughput: one gate word per cycle unless result_out stalls; bypass of the last
//   committed qubit and counter updates keeps dependent gates back to back.
// Reset (rst_n, async low): pipeline empty, all qubits and layer counters read as zero
//   at once, widest layer zero, qubits_in_use 64; no clearing pass.
`default_nettype none

module asap_gate_layering (
    input  logic                           clk,
    input  logic                           rst_n,
    agl_gate_if.sink                       gate_in,
    agl_result_if.source                   result_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [agl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [agl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [agl_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import agl_pkg::*;

    logic [QIU_W-1:0] qubits_in_use;
    stage_word_t      s1_word;
    logic             s2_ready;

    agl_apb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .qubits_in_use (qubits_in_use)
    );

    agl_qubit_stage u_qubit (
        .clk           (clk),
        .rst_n         (rst_n),
        .gate_in       (gate_in),
        .qubits_in_use (qubits_in_use),
        .s1_word       (s1_word),
        .s2_ready      (s2_ready)
    );

    agl_count_stage u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_word    (s1_word),
        .s2_ready   (s2_ready),
        .result_out (result_out)
    );

endmodule

`default_nettype wire
